// ===== rtl/cttd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttd_pkg
// Shared constants and types for the capacitive touch transition detector.
// ----------------------------------------------------------------------------
package cttd_pkg;

  localparam int unsigned CntW     = 12;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned SumW     = 16;
  localparam int unsigned CalCntW  = 4;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam int unsigned CalWindows = 10;
  localparam int unsigned CalDivInt  = ((CalWindows % 16) == 0) ? 1 : (CalWindows % 16);
  localparam int unsigned CalShift   = 20;
  localparam int unsigned CalRecipInt = ((1 << CalShift) + CalDivInt - 1) / CalDivInt;
  localparam int unsigned RecipW     = CalShift + 1;
  localparam int unsigned ProdW      = SumW + RecipW;

  localparam logic [CalCntW-1:0] CalDiv   = CalCntW'(CalDivInt);
  localparam logic [RecipW-1:0]  CalRecip = RecipW'(CalRecipInt);

  localparam logic [CntW-1:0]  CntMax        = '1;
  localparam logic [SumW-1:0]  SumMax        = '1;
  localparam logic [CntW-1:0]  WinLenReset   = CntW'(1000);
  localparam logic [ShiftW-1:0] ThrShiftReset = ShiftW'(2);

  typedef enum logic [0:0] {
    RegWinLen   = 1'b0,
    RegThrShift = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CntW-1:0]   window_length;
    logic [ShiftW-1:0] threshold_shift;
  } cfg_t;

endpackage

// ===== rtl/cttd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttd_if
// Handshake channels for comparator samples and touch results.
// ----------------------------------------------------------------------------
interface cttd_sample_if;
  logic valid;
  logic ready;
  logic comp_level;

  modport source (output valid, output comp_level, input ready);
  modport sink   (input valid, input comp_level, output ready);
endinterface

interface cttd_result_if;
  logic                     valid;
  logic                     ready;
  logic [cttd_pkg::CntW-1:0] activity;
  logic [cttd_pkg::CntW-1:0] baseline;
  logic                     touched;
  logic                     touch_changed;

  modport source (output valid, output activity, output baseline, output touched,
                  output touch_changed, input ready);
  modport sink   (input valid, input activity, input baseline, input touched,
                  input touch_changed, output ready);
endinterface

// ===== rtl/cttd_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttd_apb_regs
// APB configuration registers: window length and threshold shift.
// ----------------------------------------------------------------------------
module cttd_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cttd_pkg::ApbAddrW-1:0]     paddr,
  input  logic [cttd_pkg::ApbDataW-1:0]     pwdata,
  output logic [cttd_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output cttd_pkg::cfg_t                    cfg_o
);

  logic [cttd_pkg::CntW-1:0]   win_len_q;
  logic [cttd_pkg::ShiftW-1:0] thr_shift_q;
  logic                        wr_en;
  cttd_pkg::reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cttd_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= cttd_pkg::WinLenReset;
      thr_shift_q <= cttd_pkg::ThrShiftReset;
    end else if (wr_en) begin
      case (reg_idx)
        cttd_pkg::RegWinLen:   win_len_q   <= pwdata[cttd_pkg::CntW-1:0];
        cttd_pkg::RegThrShift: thr_shift_q <= pwdata[cttd_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cttd_pkg::RegWinLen:   prdata = cttd_pkg::ApbDataW'(win_len_q);
      cttd_pkg::RegThrShift: prdata = cttd_pkg::ApbDataW'(thr_shift_q);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.window_length   = win_len_q;
  assign cfg_o.threshold_shift = thr_shift_q;

endmodule

// ===== rtl/cttd_detect_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cttd_detect_core
// Sample register, transition counting, calibration and touch decision,
// result register.
// ----------------------------------------------------------------------------
module cttd_detect_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cttd_pkg::cfg_t         cfg_i,
  cttd_sample_if.sink            sample_i,
  cttd_result_if.source          result_o
);

  localparam int unsigned CntW = cttd_pkg::CntW;

  // sample register
  logic s1_valid_q;
  logic s1_level_q;
  logic s1_fire;

  // window state
  logic                            prev_q, prev_d;
  logic [CntW-1:0]                 idx_q, idx_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [cttd_pkg::SumW-1:0]       sum_q, sum_d;
  logic [cttd_pkg::CalCntW-1:0]    cal_done_q, cal_done_d;
  logic                            cal_pend_q, cal_pend_d;
  logic [CntW-1:0]                 base_q, base_d;
  logic                            touch_q, touch_d;

  // result register
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] act_q, base_out_q;
  logic            touched_q, changed_q;

  logic [CntW-1:0]             len;
  logic [CntW-1:0]             cnt_inc;
  logic [cttd_pkg::SumW:0]     sum_add;
  logic [CntW-1:0]             diff;
  logic [CntW-1:0]             thr;
  logic                        touched;
  logic                        res_fire;
  logic [cttd_pkg::ProdW-1:0]  prod;

  assign s1_fire        = s1_valid_q & (~out_valid_q | result_o.ready);
  assign sample_i.ready = ~s1_valid_q | s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      s1_level_q <= sample_i.comp_level;
    end
  end

  assign len     = (cfg_i.window_length == '0) ? CntW'(1) : cfg_i.window_length;
  assign cnt_inc = ((s1_level_q != prev_q) && (cnt_q != cttd_pkg::CntMax)) ?
                   cnt_q + CntW'(1) : cnt_q;
  assign sum_add = {1'b0, sum_q} + (cttd_pkg::SumW + 1)'(cnt_inc);
  assign diff    = (cnt_inc >= base_q) ? cnt_inc - base_q : base_q - cnt_inc;
  assign thr     = base_q >> cfg_i.threshold_shift;
  assign touched = diff > thr;
  assign prod    = cttd_pkg::ProdW'(sum_q) * cttd_pkg::ProdW'(cttd_pkg::CalRecip);

  always_comb begin
    prev_d      = prev_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    cal_done_d  = cal_done_q;
    cal_pend_d  = 1'b0;
    base_d      = base_q;
    touch_d     = touch_q;
    res_fire    = 1'b0;
    if (cal_pend_q) begin
      base_d = prod[cttd_pkg::CalShift +: CntW];
    end
    if (s1_fire) begin
      if (idx_q == '0) begin
        prev_d = s1_level_q;
        cnt_d  = '0;
        idx_d  = CntW'(1);
      end else begin
        prev_d = s1_level_q;
        if (idx_q < len) begin
          idx_d = idx_q + CntW'(1);
          cnt_d = cnt_inc;
        end else begin
          idx_d = '0;
          cnt_d = '0;
          if (cal_done_q < cttd_pkg::CalDiv) begin
            sum_d      = sum_add[cttd_pkg::SumW] ? cttd_pkg::SumMax
                                                 : sum_add[cttd_pkg::SumW-1:0];
            cal_done_d = cal_done_q + cttd_pkg::CalCntW'(1);
            cal_pend_d = (cal_done_d >= cttd_pkg::CalDiv);
          end else begin
            res_fire = 1'b1;
            touch_d  = touched;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      cal_done_q <= '0;
      cal_pend_q <= 1'b0;
      base_q     <= '0;
      touch_q    <= 1'b0;
    end else begin
      prev_q     <= prev_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      cal_done_q <= cal_done_d;
      cal_pend_q <= cal_pend_d;
      base_q     <= base_d;
      touch_q    <= touch_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      act_q      <= cnt_inc;
      base_out_q <= base_q;
      touched_q  <= touched;
      changed_q  <= touched ^ touch_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.activity      = act_q;
  assign result_o.baseline      = base_out_q;
  assign result_o.touched       = touched_q;
  assign result_o.touch_changed = changed_q;

`ifndef SYNTHESIS
  a_pend_at_cal_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_pend_q |-> cal_done_q == cttd_pkg::CalDiv)
    else $error("baseline update without completed calibration");

  a_no_result_before_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> !cal_pend_q && cal_done_q == cttd_pkg::CalDiv)
    else $error("result before baseline is settled");

  a_ref_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q == '0 |-> cnt_q == '0)
    else $error("stale transition count at window start");

  a_touch_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_fire |=> $stable(touch_q))
    else $error("touch state moved without a result");
`endif

endmodule

// ===== rtl/cap_touch_transition_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_touch_transition_detector
// Counts comparator transitions per window, calibrates a baseline over the
// first windows and flags touch when the count deviates from it.
// ----------------------------------------------------------------------------
// a result passes the sample and result registers after its closing request
// throughput: one sample request per cycle, stalled only by result back-pressure
// baseline is written via cal_pend_q after the last calibration window closes
// reset clears all window, calibration and touch state; registers return to
// window length 1000 and threshold shift 2
module cap_touch_transition_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cttd_pkg::ApbAddrW-1:0] paddr,
  input  logic [cttd_pkg::ApbDataW-1:0] pwdata,
  output logic [cttd_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  cttd_sample_if.sink                   sample_i,
  cttd_result_if.source                 result_o
);

  cttd_pkg::cfg_t cfg;

  cttd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cttd_detect_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (sample_i),
    .result_o (result_o)
  );

endmodule

// ===== tb/cap_touch_transition_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_touch_transition_detector_test
// Drives comparator samples through the request channel and checks every
// touch report against an internal prediction of window counting,
// baseline calibration and touch thresholding. A directed table of windows
// (calibration, zero counts, threshold edges, zero length, large shifts,
// a window shortened midway) is followed by random windows under four
// idling regimes on both channels, with register writes between phases.
// ----------------------------------------------------------------------------
module cap_touch_transition_detector_test;

  localparam int unsigned CntW     = cttd_pkg::CntW;
  localparam int unsigned ShiftW   = cttd_pkg::ShiftW;
  localparam int unsigned CalCntW  = cttd_pkg::CalCntW;
  localparam int unsigned ApbAddrW = cttd_pkg::ApbAddrW;
  localparam int unsigned ApbDataW = cttd_pkg::ApbDataW;
  localparam int unsigned CalN     = ((cttd_pkg::CalWindows % 16) == 0) ? 1 :
                                     (cttd_pkg::CalWindows % 16);

  typedef struct packed {
    logic [CntW-1:0] activity;
    logic [CntW-1:0] baseline;
    logic            touched;
    logic            touch_changed;
  } touch_report_t;

  typedef enum logic [1:0] {
    PatHold,
    PatAlt,
    PatRand,
    PatSplit
  } wave_e;

  typedef struct packed {
    logic [CntW-1:0]   win_len;
    logic [ShiftW-1:0] shift;
    wave_e             wave;
    logic              typed;
    touch_report_t     rep;
  } window_row_t;

  // calibration rows sum to 41 transitions, so the baseline is 4
  localparam window_row_t WindowRows [30] = '{
    '{12'd0,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd1,    4'd2,  PatHold,  1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd4,    4'd2,  PatAlt,   1'b0, '0},
    '{12'd12,   4'd2,  PatAlt,   1'b0, '0},
    '{12'd20,   4'd2,  PatAlt,   1'b1, '{12'd20,   12'd4, 1'b1, 1'b1}},
    '{12'd4,    4'd2,  PatAlt,   1'b1, '{12'd4,    12'd4, 1'b0, 1'b1}},
    '{12'd5,    4'd2,  PatAlt,   1'b1, '{12'd5,    12'd4, 1'b0, 1'b0}},
    '{12'd6,    4'd2,  PatAlt,   1'b1, '{12'd6,    12'd4, 1'b1, 1'b1}},
    '{12'd3,    4'd2,  PatAlt,   1'b1, '{12'd3,    12'd4, 1'b0, 1'b1}},
    '{12'd2,    4'd2,  PatAlt,   1'b1, '{12'd2,    12'd4, 1'b1, 1'b1}},
    '{12'd1,    4'd0,  PatAlt,   1'b1, '{12'd1,    12'd4, 1'b0, 1'b1}},
    '{12'd0,    4'd0,  PatAlt,   1'b1, '{12'd1,    12'd4, 1'b0, 1'b0}},
    '{12'd8,    4'd0,  PatAlt,   1'b1, '{12'd8,    12'd4, 1'b0, 1'b0}},
    '{12'd9,    4'd0,  PatAlt,   1'b1, '{12'd9,    12'd4, 1'b1, 1'b1}},
    '{12'd5,    4'd11, PatAlt,   1'b1, '{12'd5,    12'd4, 1'b1, 1'b0}},
    '{12'd4,    4'd11, PatAlt,   1'b1, '{12'd4,    12'd4, 1'b0, 1'b1}},
    '{12'd3,    4'd12, PatAlt,   1'b1, '{12'd3,    12'd4, 1'b1, 1'b1}},
    '{12'd4,    4'd15, PatAlt,   1'b1, '{12'd4,    12'd4, 1'b0, 1'b1}},
    '{12'd1,    4'd15, PatHold,  1'b1, '{12'd0,    12'd4, 1'b1, 1'b1}},
    '{12'd7,    4'd1,  PatAlt,   1'b1, '{12'd7,    12'd4, 1'b1, 1'b0}},
    '{12'd6,    4'd1,  PatAlt,   1'b1, '{12'd6,    12'd4, 1'b0, 1'b1}},
    '{12'd2,    4'd3,  PatSplit, 1'b1, '{12'd5,    12'd4, 1'b1, 1'b1}},
    '{12'd12,   4'd3,  PatRand,  1'b0, '0},
    '{12'd3,    4'd0,  PatRand,  1'b0, '0}
  };

  localparam int SrcIdlePct [4] = '{0, 73, 0, 38};
  localparam int SnkStallPct [4] = '{0, 0, 73, 38};
  localparam int FlipPcts [6] = '{100, 100, 90, 70, 0, 50};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  cttd_sample_if smp_if ();
  cttd_result_if rpt_if ();

  cap_touch_transition_detector i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample_i (smp_if),
    .result_o (rpt_if)
  );

  always #2 clk_i = ~clk_i;

  // predicted block state and register shadows
  logic [CntW-1:0]    win_len   = cttd_pkg::WinLenReset;
  logic [ShiftW-1:0]  thr_shift = cttd_pkg::ThrShiftReset;
  logic               lvl_prev  = 1'b0;
  logic [CntW-1:0]    tick_idx  = '0;
  logic [CntW-1:0]    edge_cnt  = '0;
  int unsigned        cal_sum   = 0;
  logic [CalCntW-1:0] cal_done  = '0;
  logic [CntW-1:0]    base_val  = '0;
  logic               touch_q   = 1'b0;

  touch_report_t pending_reports [$];
  int unsigned   reports_predicted = 0;
  int unsigned   mismatch_count = 0;
  int            src_idle_pct = 0;
  int            snk_stall_pct = 0;

  function automatic bit follow_comparator(input logic lvl, output touch_report_t rep);
    logic [CntW-1:0] eff_len;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] dev;
    logic [CntW-1:0] thr;
    rep = '0;
    eff_len = (win_len == '0) ? CntW'(1) : win_len;
    if (tick_idx == '0) begin
      lvl_prev = lvl;
      edge_cnt = '0;
      tick_idx = CntW'(1);
      return 1'b0;
    end
    if (lvl != lvl_prev) begin
      if (edge_cnt != cttd_pkg::CntMax) edge_cnt = edge_cnt + 1'b1;
      lvl_prev = lvl;
    end
    if (tick_idx < eff_len) begin
      tick_idx = tick_idx + 1'b1;
      return 1'b0;
    end
    cnt = edge_cnt;
    tick_idx = '0;
    edge_cnt = '0;
    if (cal_done < CalN) begin
      cal_sum = cal_sum + cnt;
      if (cal_sum > cttd_pkg::SumMax) cal_sum = cttd_pkg::SumMax;
      cal_done = cal_done + 1'b1;
      if (cal_done >= CalN) base_val = CntW'(cal_sum / CalN);
      return 1'b0;
    end
    dev = (cnt >= base_val) ? cnt - base_val : base_val - cnt;
    thr = base_val >> thr_shift;
    rep.activity = cnt;
    rep.baseline = base_val;
    rep.touched = dev > thr;
    rep.touch_changed = rep.touched != touch_q;
    touch_q = rep.touched;
    return 1'b1;
  endfunction

  function automatic void cmp_field(input string name, input logic [CntW-1:0] want,
                                    input logic [CntW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_level(input logic lvl, input logic pinned, input touch_report_t pinned_rep);
    touch_report_t rep;
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      smp_if.comp_level <= 1'($urandom_range(1));
      @(negedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.comp_level <= lvl;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    if (follow_comparator(lvl, rep)) begin
      pending_reports.push_back(pinned ? pinned_rep : rep);
      reports_predicted++;
    end
    @(negedge clk_i);
  endtask

  task automatic apb_xfer(input cttd_pkg::reg_idx_e idx, input logic wr,
                          input logic [ApbDataW-1:0] wdata,
                          output logic [ApbDataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ApbAddrW'(4 * int'(idx));
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_regs();
    logic [ApbDataW-1:0] rd;
    apb_xfer(cttd_pkg::RegWinLen, 1'b0, '0, rd);
    if (rd[CntW-1:0] !== win_len) begin
      $display("%0t: window_length expected %0d got %0d", $time, win_len, rd[CntW-1:0]);
      mismatch_count++;
    end
    apb_xfer(cttd_pkg::RegThrShift, 1'b0, '0, rd);
    if (rd[ShiftW-1:0] !== thr_shift) begin
      $display("%0t: threshold_shift expected %0d got %0d", $time, thr_shift, rd[ShiftW-1:0]);
      mismatch_count++;
    end
  endtask

  // stop requests, wait for outstanding reports, then let the pipeline empty
  task automatic settle(input int cycles);
    smp_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic set_window(input logic [CntW-1:0] len, input logic [ShiftW-1:0] sh);
    logic [ApbDataW-1:0] rd;
    settle(6);
    apb_xfer(cttd_pkg::RegWinLen, 1'b1, ApbDataW'(len), rd);
    apb_xfer(cttd_pkg::RegThrShift, 1'b1, ApbDataW'(sh), rd);
    win_len = len;
    thr_shift = sh;
    check_regs();
  endtask

  always @(negedge clk_i) begin
    rpt_if.ready <= $urandom_range(99) >= snk_stall_pct;
  end

  always @(posedge clk_i) begin : report_check
    touch_report_t want;
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report activity %0d baseline %0d touched %0b changed %0b",
                 $time, rpt_if.activity, rpt_if.baseline, rpt_if.touched, rpt_if.touch_changed);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        cmp_field("activity", want.activity, rpt_if.activity);
        cmp_field("baseline", want.baseline, rpt_if.baseline);
        cmp_field("touched", CntW'(want.touched), CntW'(rpt_if.touched));
        cmp_field("touch_changed", CntW'(want.touch_changed), CntW'(rpt_if.touch_changed));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    window_row_t       row;
    logic              lvl;
    int unsigned       n;
    int unsigned       r;
    logic [CntW-1:0]   len;
    logic [ShiftW-1:0] sh;
    int                flip_pct;
    int unsigned       ph_samples;
    int unsigned       ph_reports;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    smp_if.valid = 1'b0;
    smp_if.comp_level = 1'b0;
    lvl = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_regs();

    // directed windows
    foreach (WindowRows[i]) begin
      row = WindowRows[i];
      lvl = 1'($urandom_range(1));
      n = (row.win_len == '0) ? 2 : int'(row.win_len) + 1;
      if (row.wave == PatSplit) begin
        repeat (5) begin
          send_level(lvl, 1'b0, '0);
          lvl = ~lvl;
        end
        n = 1;
      end
      if (row.win_len != win_len || row.shift != thr_shift) set_window(row.win_len, row.shift);
      repeat (n) begin
        send_level((row.wave == PatRand) ? 1'($urandom_range(1)) : lvl, row.typed, row.rep);
        if (row.wave != PatHold) lvl = ~lvl;
      end
    end

    // random windows, chunks not aligned to window boundaries
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = SrcIdlePct[ph];
      snk_stall_pct = SnkStallPct[ph];
      ph_samples = 0;
      ph_reports = reports_predicted;
      while (ph_samples < 50 || reports_predicted - ph_reports < 4) begin
        if ($urandom_range(99) < 60) begin
          r = $urandom_range(99);
          if (r < 8) len = CntW'($urandom_range(2));
          else if (r < 78) len = CntW'($urandom_range(8, 3));
          else if (r < 98) len = CntW'($urandom_range(30, 9));
          else len = CntW'($urandom_range(60, 31));
          sh = ($urandom_range(99) < 70) ? ShiftW'($urandom_range(5))
                                         : ShiftW'($urandom_range(15, 6));
          set_window(len, sh);
        end
        flip_pct = FlipPcts[$urandom_range(5)];
        n = $urandom_range(30, 5);
        repeat (n) begin
          if ($urandom_range(99) < flip_pct) lvl = ~lvl;
          send_level(lvl, 1'b0, '0);
        end
        ph_samples += n;
      end
    end

    settle(10);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cttd_pkg.sv
rtl/cttd_if.sv
rtl/cttd_apb_regs.sv
rtl/cttd_detect_core.sv
rtl/cap_touch_transition_detector.sv
tb/cap_touch_transition_detector_test.sv
